// ===== hw/rtl/rrts_pkg.sv =====
// Shared types and constants for the round robin task scheduler.
package rrts_pkg;

    localparam int NUM_SLOTS_DEF = 8;

    localparam logic [1:0] CMD_SCHEDULE  = 2'd0;
    localparam logic [1:0] CMD_SLEEP     = 2'd1;
    localparam logic [1:0] CMD_SET_STATE = 2'd2;

    localparam logic [2:0] ST_UNUSED   = 3'd0;
    localparam logic [2:0] ST_READY    = 3'd1;
    localparam logic [2:0] ST_RUNNING  = 3'd2;
    localparam logic [2:0] ST_SLEEPING = 3'd3;
    localparam logic [2:0] ST_ZOMBIE   = 3'd4;

    localparam int STATE_W = 3;
    localparam int TIME_W  = 32;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] now_seconds;
        logic [31:0] sleep_seconds;
        logic [2:0]  slot_index;
        logic [2:0]  new_state;
    } t_sched_in;

    typedef struct packed {
        logic [2:0] active_slot;
        logic [2:0] previous_slot;
        logic       switched;
    } t_sched_out;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_SET,
        FSM_SCAN,
        FSM_WAIT,
        FSM_DEMOTE,
        FSM_PROMOTE
    } t_fsm;

endpackage

// ===== hw/rtl/rrts_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module rrts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/round_robin_task_scheduler.sv =====
// Round robin task scheduler top level: slot table in RAM, pass sequencer.
//
//  channel  direction  handshake                payload
//  in       input      i_in_valid / o_in_stall  i_in_data  (t_sched_in)
//  out      output     o_out_valid / i_out_stall o_out_data (t_sched_out)
//
// Schedule and sleep: the accept state, one RAM read per slot in the combined wake-up and
// search pass, a read-return state, then the demote and promote write-back states.
// Set state and unused commands: the accept state, then the set state. One item in flight at a time.
// Reset needs no clearing pass: per-slot valid bits give the reset table.
// A stalled output holds the finishing item; the next item is still taken.
module round_robin_task_scheduler
    import rrts_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_sched_in  i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_sched_out o_out_data
);

    localparam int SW = $clog2(NUM_SLOTS);

    t_fsm r_fsm, n_fsm;
    t_sched_in r_item, n_item;
    logic [SW-1:0] r_active, n_active;
    logic [SW-1:0] r_pos, n_pos;
    logic [SW-1:0] r_cnt, n_cnt;
    logic r_rd_vld, n_rd_vld;
    logic [SW-1:0] r_rd_pos, n_rd_pos;
    logic r_rd_first, n_rd_first;
    logic r_rd_sv, n_rd_sv;
    logic r_rd_wv, n_rd_wv;
    logic r_found, n_found;
    logic [SW-1:0] r_found_pos, n_found_pos;
    logic [STATE_W-1:0] r_act_state, n_act_state;
    logic [NUM_SLOTS-1:0] r_st_vld, n_st_vld;
    logic [NUM_SLOTS-1:0] r_wk_vld, n_wk_vld;
    logic r_out_vld, n_out_vld;
    t_sched_out r_out, n_out;

    logic st_we;
    logic [SW-1:0] st_waddr;
    logic [STATE_W-1:0] st_wdata;
    logic [STATE_W-1:0] st_q;
    logic wk_we;
    logic [TIME_W-1:0] wk_q;
    logic [SW-1:0] rd_addr;

    logic [TIME_W-1:0] deadline;
    logic [STATE_W-1:0] rd_state;
    logic [TIME_W-1:0] rd_wake;
    logic sleep_first;
    logic woke;
    logic [STATE_W-1:0] eff_state;
    logic in_acc;
    logic out_free;
    logic push;

    rrts_ram #(.WIDTH(STATE_W), .DEPTH(NUM_SLOTS)) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (rd_addr),
        .o_rdata (st_q)
    );

    rrts_ram #(.WIDTH(TIME_W), .DEPTH(NUM_SLOTS)) u_wake_ram (
        .i_clk   (i_clk),
        .i_we    (wk_we),
        .i_waddr (r_rd_pos),
        .i_wdata (deadline),
        .i_raddr (rd_addr),
        .o_rdata (wk_q)
    );

    assign deadline   = r_item.now_seconds + r_item.sleep_seconds;
    assign rd_addr    = r_pos;
    assign o_in_stall = (r_fsm != FSM_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_vld || !i_out_stall;

    // effective slot entry seen by the pass
    always_comb begin
        if (r_rd_sv) begin
            rd_state = st_q;
        end else begin
            rd_state = (r_rd_pos == '0) ? ST_RUNNING : ST_UNUSED;
        end
        rd_wake = r_rd_wv ? wk_q : '0;
        sleep_first = r_rd_first && (r_item.command == CMD_SLEEP);
        if (sleep_first) begin
            rd_state = ST_SLEEPING;
            rd_wake  = deadline;
        end
        woke = (r_rd_pos != '0) && (rd_state == ST_SLEEPING)
            && (rd_wake <= r_item.now_seconds);
        eff_state = woke ? ST_READY : rd_state;
    end

    always_comb begin
        n_fsm       = r_fsm;
        n_item      = r_item;
        n_active    = r_active;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_rd_vld    = 1'b0;
        n_rd_pos    = r_pos;
        n_rd_first  = (r_cnt == '0);
        n_rd_sv     = r_st_vld[r_pos];
        n_rd_wv     = r_wk_vld[r_pos];
        n_found     = r_found;
        n_found_pos = r_found_pos;
        n_act_state = r_act_state;
        n_st_vld    = r_st_vld;
        n_wk_vld    = r_wk_vld;
        n_out       = r_out;
        n_out_vld   = r_out_vld && i_out_stall;
        st_we       = 1'b0;
        st_waddr    = r_rd_pos;
        st_wdata    = eff_state;
        wk_we       = 1'b0;
        push        = 1'b0;

        // pass data returning from the RAMs
        if (r_rd_vld) begin
            if (sleep_first || woke) begin
                st_we = 1'b1;
            end
            if (sleep_first) begin
                wk_we = 1'b1;
                n_wk_vld[r_rd_pos] = 1'b1;
            end
            if (r_rd_first) begin
                n_act_state = eff_state;
            end
            if (!r_found && eff_state == ST_READY) begin
                n_found     = 1'b1;
                n_found_pos = r_rd_pos;
            end
        end

        case (r_fsm)
            FSM_IDLE: begin
                n_pos   = r_active;
                n_cnt   = '0;
                n_found = 1'b0;
                if (in_acc) begin
                    n_item = i_in_data;
                    if (i_in_data.command == CMD_SCHEDULE
                            || i_in_data.command == CMD_SLEEP) begin
                        n_fsm = FSM_SCAN;
                    end else begin
                        n_fsm = FSM_SET;
                    end
                end
            end
            FSM_SET: begin
                if (out_free) begin
                    if (r_item.command == CMD_SET_STATE
                            && 32'(r_item.slot_index) < NUM_SLOTS
                            && r_item.new_state <= ST_ZOMBIE) begin
                        st_we    = 1'b1;
                        st_waddr = SW'(r_item.slot_index);
                        st_wdata = r_item.new_state;
                    end
                    push  = 1'b1;
                    n_out = '{active_slot: 3'(r_active), previous_slot: 3'(r_active),
                              switched: 1'b0};
                    n_fsm = FSM_IDLE;
                end
            end
            FSM_SCAN: begin
                n_rd_vld = 1'b1;
                n_pos    = (r_pos == SW'(NUM_SLOTS - 1)) ? '0 : r_pos + 1'b1;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == SW'(NUM_SLOTS - 1)) begin
                    n_fsm = FSM_WAIT;
                end
            end
            FSM_WAIT: begin
                n_fsm = FSM_DEMOTE;
            end
            FSM_DEMOTE: begin
                if (r_found && r_act_state == ST_RUNNING) begin
                    st_we    = 1'b1;
                    st_waddr = r_active;
                    st_wdata = ST_READY;
                end
                n_fsm = FSM_PROMOTE;
            end
            FSM_PROMOTE: begin
                if (out_free) begin
                    if (r_found) begin
                        st_we    = 1'b1;
                        st_waddr = r_found_pos;
                        st_wdata = ST_RUNNING;
                        n_active = r_found_pos;
                    end
                    push  = 1'b1;
                    n_out = '{active_slot: 3'(r_found ? r_found_pos : r_active),
                              previous_slot: 3'(r_active), switched: r_found};
                    n_fsm = FSM_IDLE;
                end
            end
            default: begin
                n_fsm = FSM_IDLE;
            end
        endcase

        if (st_we) begin
            n_st_vld[st_waddr] = 1'b1;
        end
        if (push) begin
            n_out_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm     <= FSM_IDLE;
            r_active  <= '0;
            r_rd_vld  <= 1'b0;
            r_found   <= 1'b0;
            r_st_vld  <= '0;
            r_wk_vld  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_fsm     <= n_fsm;
            r_active  <= n_active;
            r_rd_vld  <= n_rd_vld;
            r_found   <= n_found;
            r_st_vld  <= n_st_vld;
            r_wk_vld  <= n_wk_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_pos       <= n_pos;
        r_cnt       <= n_cnt;
        r_rd_pos    <= n_rd_pos;
        r_rd_first  <= n_rd_first;
        r_rd_sv     <= n_rd_sv;
        r_rd_wv     <= n_rd_wv;
        r_found_pos <= n_found_pos;
        r_act_state <= n_act_state;
        r_out       <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fsm == FSM_IDLE |-> !st_we && !wk_we)
        else $error("slot table written while idle");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_fsm != FSM_IDLE)
        else $error("sequencer idle right after an accepted beat");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !(r_out_vld && i_out_stall))
        else $error("result beat overwritten while stalled");

    a_pass_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fsm == FSM_SCAN |-> 32'(r_cnt) < NUM_SLOTS)
        else $error("pass counter beyond slot count");

    a_pass_read_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fsm == FSM_DEMOTE |-> !r_rd_vld)
        else $error("pass read still returning at write-back");

endmodule

// ===== tb/tb_round_robin_task_scheduler.sv =====
// Self-checking testbench for the round robin task scheduler: queue-fed driver, predictor, monitor.
`timescale 1ns / 100ps

module tb_round_robin_task_scheduler;
    import rrts_pkg::*;

    localparam int          SLOTS          = NUM_SLOTS_DEF;
    localparam logic [1:0]  CMD_UNUSED     = 2'd3;
    localparam logic [2:0]  ST_BAD_LO      = 3'd5;
    localparam logic [2:0]  ST_BAD_HI      = 3'd7;
    localparam int          CLK_HALF_NS    = 4;
    localparam int          RST_CYCLES     = 4;
    localparam int          RAND_PER_PHASE = 125;
    localparam int          RX_HOLD_CYCLES = 200;
    localparam int          TAIL_CYCLES    = 40;
    localparam int          TIMEOUT_NS     = 3_000_000;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       in_vld    = 1'b0;
    t_sched_in  in_dat    = '0;
    logic       out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_sched_out o_out_data;

    round_robin_task_scheduler DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_vld),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_dat),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // predictor state
    logic [2:0]  slot_st [SLOTS];
    logic [31:0] wake_at [SLOTS];
    int          cur_slot;

    t_sched_in   cmd_backlog [$];
    t_sched_out  expected_outcomes [$];

    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    logic hold_send     = 1'b0;
    logic rx_hold       = 1'b0;
    logic rx_hold_go    = 1'b0;
    logic in_taken      = 1'b0;
    logic [31:0] uptime = '0;

    int err_cnt       = 0;
    int results_seen  = 0;
    int switches_seen = 0;
    int cmd_seen [4]  = '{0, 0, 0, 0};

    // wake-up pass then round robin search; returns 1 on a switch
    function automatic logic rr_pass(logic [31:0] now);
        int pos;
        for (int i = 1; i < SLOTS; i++) begin
            if (slot_st[i] == ST_SLEEPING && wake_at[i] <= now) begin
                slot_st[i] = ST_READY;
            end
        end
        pos = cur_slot;
        for (int n = 0; n <= SLOTS; n++) begin
            if (slot_st[pos] == ST_READY) begin
                if (slot_st[cur_slot] == ST_RUNNING) begin
                    slot_st[cur_slot] = ST_READY;
                end
                cur_slot = pos;
                slot_st[pos] = ST_RUNNING;
                return 1'b1;
            end
            pos = (pos + 1) % SLOTS;
        end
        return 1'b0;
    endfunction

    function automatic t_sched_out next_outcome(t_sched_in it);
        t_sched_out res;
        int         prev;
        logic       sw;
        prev = cur_slot;
        sw   = 1'b0;
        case (it.command)
            CMD_SCHEDULE: begin
                sw = rr_pass(it.now_seconds);
            end
            CMD_SLEEP: begin
                wake_at[prev] = it.now_seconds + it.sleep_seconds;
                slot_st[prev] = ST_SLEEPING;
                sw = rr_pass(it.now_seconds);
            end
            CMD_SET_STATE: begin
                if (int'(it.slot_index) < SLOTS && it.new_state <= ST_ZOMBIE) begin
                    slot_st[it.slot_index] = it.new_state;
                end
            end
            default: begin
            end
        endcase
        res.active_slot   = 3'(cur_slot);
        res.previous_slot = 3'(prev);
        res.switched      = sw;
        return res;
    endfunction

    task automatic queue_cmd(logic [1:0] cmd, logic [31:0] now, logic [31:0] secs,
                             logic [2:0] slot, logic [2:0] st);
        t_sched_in it;
        it.command       = cmd;
        it.now_seconds   = now;
        it.sleep_seconds = secs;
        it.slot_index    = slot;
        it.new_state     = st;
        cmd_backlog.push_back(it);
    endtask

    // mostly well-formed traffic: time moves forward, slots get readied and put to sleep
    task automatic queue_random_cmd();
        int          r;
        logic [1:0]  cmd;
        logic [31:0] secs;
        logic [2:0]  st;
        r = $urandom_range(99);
        if (r < 35) begin
            cmd = CMD_SCHEDULE;
        end else if (r < 55) begin
            cmd = CMD_SLEEP;
        end else if (r < 95) begin
            cmd = CMD_SET_STATE;
        end else begin
            cmd = CMD_UNUSED;
        end
        r = $urandom_range(99);
        if (r < 4) begin
            uptime = $urandom;
        end else if (r < 6) begin
            uptime = 32'hFFFF_FFF0 + 32'($urandom_range(0, 15));
        end else begin
            uptime = uptime + 32'($urandom_range(0, 5));
        end
        secs = ($urandom_range(9) == 0) ? 32'($urandom) : 32'($urandom_range(0, 20));
        st   = ($urandom_range(1) == 0) ? ST_READY : 3'($urandom_range(0, 7));
        queue_cmd(cmd, uptime, secs, 3'($urandom_range(0, 7)), st);
    endtask

    task automatic drain();
        while (cmd_backlog.size() != 0 || in_vld || expected_outcomes.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_vld <= 1'b0;
        end else if (!in_vld || in_taken) begin
            in_taken = 1'b0;
            if (hold_send || cmd_backlog.size() == 0 || $urandom_range(99) < send_idle_pct) begin
                in_vld <= 1'b0;
            end else begin
                in_vld <= 1'b1;
                in_dat <= cmd_backlog.pop_front();
            end
        end
    end

    always @(negedge i_clk) begin
        out_stall <= rx_hold || ($urandom_range(99) < stall_pct);
    end

    // long receiver hold-off
    initial begin
        wait (rx_hold_go);
        rx_hold = 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    // monitor and input beat capture
    always @(posedge i_clk) begin
        t_sched_out want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            results_seen++;
            if (expected_outcomes.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10) begin
                    $display("%0t: unexpected result beat act=%0d prev=%0d sw=%0d", $realtime,
                             o_out_data.active_slot, o_out_data.previous_slot,
                             o_out_data.switched);
                end
            end else begin
                want = expected_outcomes.pop_front();
                if (want.switched) begin
                    switches_seen++;
                end
                if (o_out_data.active_slot !== want.active_slot ||
                    o_out_data.previous_slot !== want.previous_slot ||
                    o_out_data.switched !== want.switched) begin
                    err_cnt++;
                    if (err_cnt <= 10) begin
                        $display("%0t: mismatch exp act=%0d prev=%0d sw=%0d, got act=%0d prev=%0d sw=%0d",
                                 $realtime, want.active_slot, want.previous_slot, want.switched,
                                 o_out_data.active_slot, o_out_data.previous_slot,
                                 o_out_data.switched);
                    end
                end
            end
        end
        if (i_rst_n && in_vld && !o_in_stall) begin
            expected_outcomes.push_back(next_outcome(in_dat));
            cmd_seen[in_dat.command]++;
            in_taken = 1'b1;
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb_round_robin_task_scheduler: FAIL");
        $finish;
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            slot_st[i] = ST_UNUSED;
            wake_at[i] = '0;
        end
        slot_st[0] = ST_RUNNING;
        cur_slot   = 0;

        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed
        queue_cmd(CMD_SCHEDULE,  32'd0, 32'd0, 3'd0, ST_UNUSED);
        queue_cmd(CMD_SET_STATE, 32'd0, 32'd0, 3'd1, ST_READY);
        queue_cmd(CMD_SET_STATE, 32'd0, 32'd0, 3'd7, ST_READY);
        queue_cmd(CMD_SCHEDULE,  32'd0, 32'd0, 3'd0, ST_UNUSED);
        queue_cmd(CMD_SLEEP,     32'd100, 32'd50, 3'd0, ST_UNUSED);
        queue_cmd(CMD_SCHEDULE,  32'd149, 32'd0, 3'd0, ST_UNUSED);
        queue_cmd(CMD_SCHEDULE,  32'd150, 32'd0, 3'd0, ST_UNUSED);
        queue_cmd(CMD_SET_STATE, 32'd150, 32'd0, 3'd2, ST_BAD_LO);
        queue_cmd(CMD_SET_STATE, 32'd150, 32'd0, 3'd6, ST_BAD_HI);
        queue_cmd(CMD_UNUSED,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, ST_BAD_HI);
        queue_cmd(CMD_SET_STATE, 32'd150, 32'd0, 3'd1, ST_ZOMBIE);
        queue_cmd(CMD_SCHEDULE,  32'd150, 32'd0, 3'd0, ST_UNUSED);
        queue_cmd(CMD_SET_STATE, 32'd150, 32'd0, 3'd7, ST_READY);
        queue_cmd(CMD_SCHEDULE,  32'd150, 32'd0, 3'd0, ST_UNUSED);
        // deadline wraps past 2^32
        queue_cmd(CMD_SLEEP,     32'hFFFF_FFF0, 32'h20, 3'd0, ST_UNUSED);
        // the running slot goes to sleep with a deadline already reached
        queue_cmd(CMD_SLEEP,     32'd0, 32'd0, 3'd0, ST_UNUSED);
        queue_cmd(CMD_SCHEDULE,  32'h10, 32'd0, 3'd0, ST_UNUSED);
        queue_cmd(CMD_SCHEDULE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd0, ST_UNUSED);
        queue_cmd(CMD_SET_STATE, 32'd0, 32'd0, 3'd0, ST_READY);
        queue_cmd(CMD_SCHEDULE,  32'd0, 32'd0, 3'd0, ST_UNUSED);
        queue_cmd(CMD_SET_STATE, 32'd0, 32'd0, 3'd3, ST_SLEEPING);
        queue_cmd(CMD_SET_STATE, 32'd0, 32'd0, 3'd2, ST_RUNNING);
        queue_cmd(CMD_SCHEDULE,  32'd0, 32'd0, 3'd0, ST_UNUSED);
        queue_cmd(CMD_SLEEP,     32'd5, 32'hFFFF_FFFF, 3'd0, ST_UNUSED);
        drain();

        // no idling, with a long receiver hold-off at the start
        uptime = 32'd200;
        rx_hold_go = 1'b1;
        repeat (RAND_PER_PHASE) queue_random_cmd();
        drain();

        // sender idles, pauses once until all results are back
        send_idle_pct = 79;
        repeat (RAND_PER_PHASE / 2) queue_random_cmd();
        while (cmd_backlog.size() != 0) @(negedge i_clk);
        hold_send = 1'b1;
        while (in_vld || expected_outcomes.size() != 0) @(negedge i_clk);
        hold_send = 1'b0;
        repeat (RAND_PER_PHASE - RAND_PER_PHASE / 2) queue_random_cmd();
        drain();

        send_idle_pct = 0;
        stall_pct     = 79;
        repeat (RAND_PER_PHASE) queue_random_cmd();
        drain();

        send_idle_pct = 8;
        stall_pct     = 8;
        repeat (RAND_PER_PHASE) queue_random_cmd();
        drain();

        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d schedule, %0d sleep, %0d set-state, %0d unused commands;",
                 cmd_seen[CMD_SCHEDULE], cmd_seen[CMD_SLEEP], cmd_seen[CMD_SET_STATE],
                 cmd_seen[CMD_UNUSED]);
        $display("%0d results checked, %0d task switches, %0d mismatches.",
                 results_seen, switches_seen, err_cnt);
        if (err_cnt == 0 && expected_outcomes.size() == 0) begin
            $display("tb_round_robin_task_scheduler: PASS");
        end else begin
            $display("tb_round_robin_task_scheduler: FAIL");
        end
        $finish;
    end

endmodule
